FILE: src/usblhm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usblhm_pkg
// shared types and constants of the usb link health monitor
// ----------------------------------------------------------------------------
package usblhm_pkg;

   // event codes carried by an input item
   typedef enum logic [1:0] {
      ACT_POLL   = 2'd0,
      ACT_FEED   = 2'd1,
      ACT_RESULT = 2'd2,
      ACT_START  = 2'd3
   } action_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_FEED_TIMEOUT    = 2'd0,
      CSR_RECONNECT_DELAY = 2'd1,
      CSR_STALL_LIMIT     = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned FRAME_W = 11;
   localparam int unsigned RUN_W   = 4;

   localparam logic [TIME_W-1:0] FEED_TIMEOUT_RST    = 32'd5000;
   localparam logic [TIME_W-1:0] RECONNECT_DELAY_RST = 32'd1000;
   localparam logic [RUN_W-1:0]  STALL_LIMIT_RST     = 4'd3;
   localparam logic [RUN_W-1:0]  RUN_MAX             = 4'd15;

endpackage

FILE: src/usblhm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usblhm interfaces
// valid/ready channels for events, results and register writes
// ----------------------------------------------------------------------------
interface usblhm_req_if import usblhm_pkg::*; ();
   logic                valid;
   logic                ready;
   action_type          action;
   logic [TIME_W-1:0]   now_ms;
   logic                configured;
   logic [FRAME_W-1:0]  frame_number;
   logic                reset_failed;

   modport source (output valid, action, now_ms, configured, frame_number,
                   reset_failed, input ready);
   modport sink   (input valid, action, now_ms, configured, frame_number,
                   reset_failed, output ready);
endinterface

interface usblhm_rsp_if import usblhm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                stall_reset_request;
   logic                reconnect_reset_request;
   logic                feed_timeout;
   logic                stalled_now;
   logic [TIME_W-1:0]   error_total;
   logic [TIME_W-1:0]   uptime_ms;

   modport source (output valid, stall_reset_request, reconnect_reset_request,
                   feed_timeout, stalled_now, error_total, uptime_ms,
                   input ready);
   modport sink   (input valid, stall_reset_request, reconnect_reset_request,
                   feed_timeout, stalled_now, error_total, uptime_ms,
                   output ready);
endinterface

interface usblhm_csr_if import usblhm_pkg::*; ();
   logic                valid;
   logic                ready;
   csr_index_type       index;
   logic [TIME_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/usb_link_health_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_link_health_monitor_top
// watches frame progress, disconnects and feeds, requests controller resets
// ----------------------------------------------------------------------------
//  channel    dir   carries
//  req_chan   in    one event item: action, time, configured flag, frame, outcome
//  rsp_chan   out   one result item per event: requests, flags, error count, uptime
//  csr_chan   in    register write: index and data, always ready
//
//  one item per cycle sustained while rsp_ready stays high; an item goes through the
//  input register, then the single pass of update logic into the result register
//  all monitor state is read and rewritten in that one pass, so back to back
//  items see each other's effects without bubbles
//  synchronous active-high reset clears the state and loads register defaults
//  rsp_ready low holds the result; the input register still takes one item
// ----------------------------------------------------------------------------
module usb_link_health_monitor_top import usblhm_pkg::*; #(
   parameter int unsigned HISTORY_DEPTH = 3
) (
   input  logic          clock,
   input  logic          reset,
   usblhm_req_if.sink    req_chan,
   usblhm_rsp_if.source  rsp_chan,
   usblhm_csr_if.sink    csr_chan
);

   localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

   // configuration registers
   logic [TIME_W-1:0]  feed_timeout_ff;
   logic [TIME_W-1:0]  reconnect_delay_ff;
   logic [RUN_W-1:0]   stall_limit_ff;

   // input register
   logic               s1_valid_ff;
   action_type         s1_action_ff;
   logic [TIME_W-1:0]  s1_now_ff;
   logic               s1_cfg_ff;
   logic [FRAME_W-1:0] s1_frame_ff;
   logic               s1_failed_ff;

   // result register
   logic               out_valid_ff;
   logic               out_stall_req_ff;
   logic               out_recon_req_ff;
   logic               out_timeout_ff;
   logic               out_stalled_ff;
   logic [TIME_W-1:0]  out_err_ff;
   logic [TIME_W-1:0]  out_uptime_ff;

   // monitor state
   logic [FRAME_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [FRAME_W-1:0] hist_in [HISTORY_DEPTH];
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               was_cfg_ff, was_cfg_in;
   logic [TIME_W-1:0]  disc_ff, disc_in;
   logic [TIME_W-1:0]  feed_ff, feed_in;
   logic [TIME_W-1:0]  err_ff, err_in;
   logic [TIME_W-1:0]  boot_ff, boot_in;

   // per-item results
   logic               stall_req_in;
   logic               recon_req_in;
   logic               timeout_in;
   logic               stalled_in;
   logic [TIME_W-1:0]  uptime_in;

   // working values of the pass
   logic [FRAME_W-1:0] hist_wr [HISTORY_DEPTH];
   logic               ring_uniform;
   logic [RUN_W-1:0]   run_inc;
   logic [TIME_W-1:0]  disc_mid;
   logic               advance;

   // handshakes
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid                   = out_valid_ff;
   assign rsp_chan.stall_reset_request     = out_stall_req_ff;
   assign rsp_chan.reconnect_reset_request = out_recon_req_ff;
   assign rsp_chan.feed_timeout            = out_timeout_ff;
   assign rsp_chan.stalled_now             = out_stalled_ff;
   assign rsp_chan.error_total             = out_err_ff;
   assign rsp_chan.uptime_ms               = out_uptime_ff;

   // register writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_timeout_ff    <= FEED_TIMEOUT_RST;
         reconnect_delay_ff <= RECONNECT_DELAY_RST;
         stall_limit_ff     <= STALL_LIMIT_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FEED_TIMEOUT:    feed_timeout_ff    <= csr_chan.data;
            CSR_RECONNECT_DELAY: reconnect_delay_ff <= csr_chan.data;
            CSR_STALL_LIMIT:     stall_limit_ff     <= csr_chan.data[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_action_ff <= req_chan.action;
         s1_now_ff    <= req_chan.now_ms;
         s1_cfg_ff    <= req_chan.configured;
         s1_frame_ff  <= req_chan.frame_number;
         s1_failed_ff <= req_chan.reset_failed;
      end
   end

   // ring with this frame written at the current slot
   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_wr[i] = (slot_ff == SLOT_W'(i)) ? s1_frame_ff : hist_ff[i];
      end
      ring_uniform = 1'b1;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         if (hist_wr[i] != hist_wr[0]) ring_uniform = 1'b0;
      end
   end

   assign run_inc  = (run_ff == RUN_MAX) ? run_ff : run_ff + 4'd1;
   // a drop of the configured flag stamps the disconnect time
   assign disc_mid = (!s1_cfg_ff && was_cfg_ff) ? s1_now_ff : disc_ff;

   // single pass of the monitor update
   always_comb begin
      hist_in      = hist_ff;
      slot_in      = slot_ff;
      run_in       = run_ff;
      was_cfg_in   = was_cfg_ff;
      disc_in      = disc_ff;
      feed_in      = feed_ff;
      err_in       = err_ff;
      boot_in      = boot_ff;
      stall_req_in = 1'b0;
      recon_req_in = 1'b0;
      timeout_in   = 1'b0;
      stalled_in   = 1'b0;

      case (s1_action_ff)
         ACT_POLL: begin
            if (!s1_cfg_ff) begin
               // not configured: ring dropped, stall run kept
               hist_in = '{default: '0};
               slot_in = '0;
            end else begin
               hist_in = hist_wr;
               slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
               if (ring_uniform && (hist_wr[0] != '0)) begin
                  stalled_in = 1'b1;
                  run_in     = run_inc;
                  if (run_inc >= stall_limit_ff) begin
                     stall_req_in = 1'b1;
                     hist_in      = '{default: '0};
                     slot_in      = '0;
                     run_in       = '0;
                  end
               end else begin
                  run_in = '0;
               end
            end

            // reconnect once the delay since the disconnect has run out
            disc_in = disc_mid;
            if (!s1_cfg_ff && (disc_mid != '0) &&
                ((s1_now_ff - disc_mid) > reconnect_delay_ff)) begin
               recon_req_in = 1'b1;
               hist_in      = '{default: '0};
               slot_in      = '0;
               run_in       = '0;
               disc_in      = '0;
            end
            was_cfg_in = s1_cfg_ff;

            // feed lapse: flag, count and restart the feed timer
            if ((feed_ff != '0) && ((s1_now_ff - feed_ff) > feed_timeout_ff)) begin
               timeout_in = 1'b1;
               err_in     = err_ff + 32'd1;
               feed_in    = s1_now_ff;
            end
         end
         ACT_FEED: begin
            feed_in = s1_now_ff;
         end
         ACT_RESULT: begin
            if (s1_failed_ff) err_in = err_ff + 32'd1;
         end
         ACT_START: begin
            // fresh start: keep connection tracking and registers
            hist_in = '{default: '0};
            slot_in = '0;
            run_in  = '0;
            feed_in = '0;
            err_in  = '0;
            boot_in = s1_now_ff;
         end
         default: ;
      endcase

      uptime_in = s1_now_ff - boot_in;
   end

   // state commits only when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '{default: '0};
         slot_ff    <= '0;
         run_ff     <= '0;
         was_cfg_ff <= 1'b0;
         disc_ff    <= '0;
         feed_ff    <= '0;
         err_ff     <= '0;
         boot_ff    <= '0;
      end else if (advance) begin
         hist_ff    <= hist_in;
         slot_ff    <= slot_in;
         run_ff     <= run_in;
         was_cfg_ff <= was_cfg_in;
         disc_ff    <= disc_in;
         feed_ff    <= feed_in;
         err_ff     <= err_in;
         boot_ff    <= boot_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_stall_req_ff <= stall_req_in;
         out_recon_req_ff <= recon_req_in;
         out_timeout_ff   <= timeout_in;
         out_stalled_ff   <= stalled_in;
         out_err_ff       <= err_in;
         out_uptime_ff    <= uptime_in;
      end
   end

   // checks

   // a stall request only ever comes from a stalled tick
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stall_req_ff |-> out_stalled_ff)
      else $error("stall request without stalled tick");

   // stall needs configured, reconnect needs not configured
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_stall_req_ff && out_recon_req_ff))
      else $error("stall and reconnect requests together");

   // ring pointer stays inside the ring
   assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("history slot out of range");

   // a new result is only loaded from a held input item
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !$past(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an input item");

endmodule

FILE: test/usb_link_health_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_link_health_monitor_top_tb
// drives poll, feed, reset-outcome and start items into the link health
// monitor, predicts every result item in step and compares it field by field
// ----------------------------------------------------------------------------
module usb_link_health_monitor_top_tb;
   import usblhm_pkg::*;

   localparam int unsigned RING_DEPTH    = 3;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS   = 185;

   // one predicted result item
   typedef struct packed {
      logic              stall_req;
      logic              recon_req;
      logic              timeout;
      logic              stalled;
      logic [TIME_W-1:0] errors;
      logic [TIME_W-1:0] uptime;
   } health_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   usblhm_req_if req_if ();
   usblhm_rsp_if rsp_if ();
   usblhm_csr_if csr_if ();

   usb_link_health_monitor_top #(
      .HISTORY_DEPTH (RING_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predictor copy of the monitor state
   logic [FRAME_W-1:0] frame_ring [RING_DEPTH];
   int unsigned        ring_slot;
   logic [RUN_W-1:0]   stall_count;
   logic               link_was_up;
   logic [TIME_W-1:0]  drop_stamp;
   logic [TIME_W-1:0]  feed_stamp;
   logic [TIME_W-1:0]  fault_tally;
   logic [TIME_W-1:0]  start_stamp;

   // predictor copy of the registers
   logic [TIME_W-1:0]  feed_limit;
   logic [TIME_W-1:0]  reconnect_wait;
   logic [RUN_W-1:0]   stall_threshold;

   // results still owed by the block, oldest first
   health_type         pending_health [$];

   int unsigned        fail_count  = 0;
   int unsigned        cycle_count = 0;
   bit                 idle_on     = 1'b1;
   int unsigned        hold_ticks  = 0;
   int unsigned        ready_gap   = 0;

   // running link picture used to build plausible event streams
   logic [TIME_W-1:0]  link_ms    = '0;
   logic               link_cfg   = 1'b1;
   logic [FRAME_W-1:0] link_frame = '0;
   int unsigned        stuck_left = 0;

   function automatic void clear_history();
      foreach (frame_ring[i]) frame_ring[i] = '0;
      ring_slot = 0;
   endfunction

   // works out the result of one event and advances the predictor state
   function automatic health_type predict_health(action_type act, logic [TIME_W-1:0] now,
                                                 logic cfg, logic [FRAME_W-1:0] frame,
                                                 logic failed);
      health_type r;
      logic       same;
      r = '0;
      case (act)
         ACT_POLL: begin
            if (!cfg) begin
               // unconfigured poll empties the ring but keeps the stall run
               clear_history();
            end else begin
               frame_ring[ring_slot] = frame;
               ring_slot = (ring_slot + 1) % RING_DEPTH;
               same = 1'b1;
               for (int i = 1; i < RING_DEPTH; i++)
                  if (frame_ring[i] != frame_ring[0]) same = 1'b0;
               if (same && frame_ring[0] != '0) begin
                  r.stalled = 1'b1;
                  if (stall_count != RUN_MAX) stall_count++;
                  // a limit of zero is met on every stalled poll
                  if (stall_count >= stall_threshold) begin
                     r.stall_req = 1'b1;
                     clear_history();
                     stall_count = '0;
                  end
               end else begin
                  stall_count = '0;
               end
            end
            // falling configured flag stamps the disconnect, zero means none
            if (!cfg && link_was_up) drop_stamp = now;
            if (!cfg && drop_stamp != '0 && (now - drop_stamp) > reconnect_wait) begin
               r.recon_req = 1'b1;
               clear_history();
               stall_count = '0;
               drop_stamp  = '0;
            end
            link_was_up = cfg;
            // a restart of the feed timer at time zero leaves it unfed
            if (feed_stamp != '0 && (now - feed_stamp) > feed_limit) begin
               r.timeout = 1'b1;
               fault_tally++;
               feed_stamp = now;
            end
         end
         ACT_FEED: feed_stamp = now;
         ACT_RESULT: if (failed) fault_tally++;
         default: begin
            clear_history();
            stall_count = '0;
            feed_stamp  = '0;
            fault_tally = '0;
            start_stamp = now;
         end
      endcase
      r.errors = fault_tally;
      r.uptime = now - start_stamp;
      return r;
   endfunction

   // offers one item, optionally after a random idle burst, and books its result
   task automatic send_event(action_type act, logic [TIME_W-1:0] now, logic cfg,
                             logic [FRAME_W-1:0] frame, logic failed);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.action       <= act;
      req_if.now_ms       <= now;
      req_if.configured   <= cfg;
      req_if.frame_number <= frame;
      req_if.reset_failed <= failed;
      do @(posedge clock); while (!req_if.ready);
      pending_health.push_back(predict_health(act, now, cfg, frame, failed));
   endtask

   // sender goes quiet until every owed result has come back
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (pending_health.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [TIME_W-1:0] value, bit last);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_FEED_TIMEOUT:    feed_limit      = value;
         CSR_RECONNECT_DELAY: reconnect_wait  = value;
         CSR_STALL_LIMIT:     stall_threshold = value[RUN_W-1:0];
         default: ;
      endcase
      if (last) csr_if.valid <= 1'b0;
   endtask

   // full register set, preceded by a write to the unused index that must be ignored
   task automatic load_settings(logic [TIME_W-1:0] timeout_ms, logic [TIME_W-1:0] delay_ms,
                                logic [TIME_W-1:0] limit_word);
      write_register(CSR_UNUSED, $urandom, 1'b0);
      write_register(CSR_FEED_TIMEOUT, timeout_ms, 1'b0);
      write_register(CSR_RECONNECT_DELAY, delay_ms, 1'b0);
      write_register(CSR_STALL_LIMIT, limit_word, 1'b1);
   endtask

   task automatic check_field(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // short hand-built stream at reset settings: zero and full frames, time wrap,
   // never-fed feed, timeout edge, disconnect timing and zero stamps
   task automatic test_directed_events();
      send_event(ACT_START,  32'hFFFF_FF00, 1'b1, 11'd0,    1'b0);
      send_event(ACT_POLL,   32'hFFFF_FF64, 1'b1, 11'd0,    1'b1);
      send_event(ACT_POLL,   32'hFFFF_FFC8, 1'b1, 11'd0,    1'b0);
      // uptime wraps past zero while the full frame value sticks
      send_event(ACT_POLL,   32'h0000_002C, 1'b1, 11'h7FF,  1'b0);
      send_event(ACT_POLL,   32'h0000_0090, 1'b1, 11'h7FF,  1'b0);
      send_event(ACT_POLL,   32'h0000_00F4, 1'b1, 11'h7FF,  1'b1);
      send_event(ACT_POLL,   32'h0000_0158, 1'b1, 11'h7FF,  1'b0);
      send_event(ACT_POLL,   32'h0000_01BC, 1'b1, 11'h7FF,  1'b0);
      // feed at time zero counts as never fed
      send_event(ACT_FEED,   32'd0,         1'b0, 11'h7FF,  1'b1);
      send_event(ACT_POLL,   32'hFFFF_FFFF, 1'b1, 11'd1,    1'b0);
      send_event(ACT_FEED,   32'd100,       1'b1, 11'd0,    1'b0);
      send_event(ACT_POLL,   32'd5100,      1'b1, 11'd2,    1'b0);
      send_event(ACT_POLL,   32'd5101,      1'b1, 11'd3,    1'b0);
      send_event(ACT_RESULT, 32'd5200,      1'b1, 11'd3,    1'b1);
      send_event(ACT_RESULT, 32'd5300,      1'b0, 11'h555,  1'b0);
      // disconnect, then one poll on the delay and one just past it
      send_event(ACT_POLL,   32'd6000,      1'b0, 11'd4,    1'b0);
      send_event(ACT_POLL,   32'd7000,      1'b0, 11'd4,    1'b0);
      send_event(ACT_POLL,   32'd7001,      1'b0, 11'd4,    1'b0);
      // feed timer wraps and restarts at time zero, so it reads as never fed
      send_event(ACT_POLL,   32'd0,         1'b1, 11'd5,    1'b0);
      // disconnect stamped at time zero leaves nothing pending
      send_event(ACT_POLL,   32'd0,         1'b0, 11'd5,    1'b0);
      send_event(ACT_POLL,   32'd5000,      1'b0, 11'd5,    1'b0);
      send_event(ACT_START,  32'd12345,     1'b1, 11'h2AA,  1'b1);
      send_event(ACT_POLL,   32'd12400,     1'b1, 11'd5,    1'b0);
      link_ms  = 32'd12400;
      link_cfg = 1'b1;
   endtask

   // long runs of one frame under stall limits zero, one, fifteen and seven;
   // zero and seven arrive with upper bits set that the register drops
   task automatic test_stall_limits();
      logic [TIME_W-1:0]  limit_word;
      logic [FRAME_W-1:0] stuck;
      for (int k = 0; k < 4; k++) begin
         wait_for_results();
         case (k)
            0:       limit_word = 32'hFFFF_FFF0;
            1:       limit_word = 32'd1;
            2:       limit_word = 32'd15;
            default: limit_word = 32'h17;
         endcase
         load_settings(FEED_TIMEOUT_RST, RECONNECT_DELAY_RST, limit_word);
         link_ms += 100;
         send_event(ACT_START, link_ms, 1'b1, 11'd0, 1'b0);
         stuck = FRAME_W'($urandom_range(1, 2046));
         for (int n = 0; n < 20; n++) begin
            link_ms += 100;
            // one odd frame mid-run breaks the streak
            send_event(ACT_POLL, link_ms, 1'b1, (n == 9) ? stuck + 11'd1 : stuck, 1'b0);
         end
      end
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_backpressure();
      wait_for_results();
      idle_on    = 1'b0;
      hold_ticks = 300;
      for (int n = 0; n < 40; n++) begin
         link_ms += $urandom_range(1, 200);
         send_event(n % 7 == 3 ? ACT_FEED : ACT_POLL, link_ms, $urandom_range(0, 7) != 0,
                    FRAME_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
      // sender pauses until the backlog has fully drained
      wait_for_results();
      idle_on = 1'b1;
   endtask

   // random phases of plausible traffic under several register settings;
   // the last phase runs without any idling
   task automatic test_random_traffic();
      int unsigned pick;
      int unsigned sel;
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_results();
         case (phase)
            0:       load_settings(FEED_TIMEOUT_RST, RECONNECT_DELAY_RST, STALL_LIMIT_RST);
            1:       load_settings(32'd1, 32'd1, 32'd1);
            2:       load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15);
            3:       load_settings(32'd300, 32'd400, 32'd2);
            4:       load_settings($urandom_range(100, 3000), $urandom_range(100, 3000),
                                   $urandom);
            default: load_settings(32'd150, 32'd250, 32'd4);
         endcase
         idle_on = (phase != 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mostly small time steps, some long gaps, rarely a jump anywhere
            sel = $urandom_range(0, 99);
            if (sel < 80)      link_ms += $urandom_range(1, 150);
            else if (sel < 97) link_ms += $urandom_range(151, 4000);
            else               link_ms = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               if ($urandom_range(0, 99) < 6) link_cfg = ~link_cfg;
               // frames advance, but now and then freeze for a stretch
               if (stuck_left != 0) begin
                  stuck_left--;
               end else if ($urandom_range(0, 9) == 0) begin
                  stuck_left = $urandom_range(1, 20);
               end else begin
                  sel = $urandom_range(0, 99);
                  if (sel < 5)      link_frame = FRAME_W'($urandom_range(0, 2047));
                  else if (sel < 8) link_frame = '0;
                  else              link_frame++;
               end
               send_event(ACT_POLL, link_ms, link_cfg, link_frame,
                          1'($urandom_range(0, 1)));
            end else if (pick < 84) begin
               send_event(ACT_FEED, link_ms, 1'($urandom_range(0, 1)),
                          FRAME_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
            end else if (pick < 96) begin
               send_event(ACT_RESULT, link_ms, 1'($urandom_range(0, 1)),
                          FRAME_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
            end else begin
               send_event(ACT_START, link_ms, 1'($urandom_range(0, 1)),
                          FRAME_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   // result side: long hold-off first, then random stall bursts when enabled
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_ticks != 0) begin
         hold_ticks--;
         rsp_if.ready <= 1'b0;
      end else if (ready_gap != 0) begin
         ready_gap--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         ready_gap = $urandom_range(0, 15);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // compares each accepted result with the oldest prediction; also the watchdog
   always @(posedge clock) begin
      health_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_health.size() == 0) begin
            fail_count++;
            $display("%0t ns unexpected result item: expected none, actual uptime %0h",
                     $time, rsp_if.uptime_ms);
         end else begin
            want = pending_health.pop_front();
            check_field("stall_reset_request", TIME_W'(want.stall_req),
                        TIME_W'(rsp_if.stall_reset_request));
            check_field("reconnect_reset_request", TIME_W'(want.recon_req),
                        TIME_W'(rsp_if.reconnect_reset_request));
            check_field("feed_timeout", TIME_W'(want.timeout),
                        TIME_W'(rsp_if.feed_timeout));
            check_field("stalled_now", TIME_W'(want.stalled),
                        TIME_W'(rsp_if.stalled_now));
            check_field("error_total", want.errors, rsp_if.error_total);
            check_field("uptime_ms", want.uptime, rsp_if.uptime_ms);
         end
      end
   end

   initial begin
      req_if.valid        <= 1'b0;
      req_if.action       <= ACT_POLL;
      req_if.now_ms       <= '0;
      req_if.configured   <= 1'b0;
      req_if.frame_number <= '0;
      req_if.reset_failed <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= CSR_FEED_TIMEOUT;
      csr_if.data         <= '0;

      // predictor starts from the reset picture
      feed_limit      = FEED_TIMEOUT_RST;
      reconnect_wait  = RECONNECT_DELAY_RST;
      stall_threshold = STALL_LIMIT_RST;
      clear_history();
      stall_count = '0;
      link_was_up = 1'b0;
      drop_stamp  = '0;
      feed_stamp  = '0;
      fault_tally = '0;
      start_stamp = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_events();
      test_stall_limits();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      // let the bench settle to catch any stray result item
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_health.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
